/* src/dsp_pkg.sv */
// ----------------------------------------------------------------------------
// dsp_pkg: shared types and constants for the dual stepper sequencer
// Widths, reset values, mode and register codes, channel result bundle.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int DELAY_W    = 16;
  localparam int COIL_W     = 4;
  localparam int POS_W      = 3;
  localparam int MODE_W     = 2;
  localparam int PAT_W      = 32;
  localparam int RAMP_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DELAY_W-1:0] START_DELAY    = DELAY_W'(1000);
  localparam logic [DELAY_W-1:0] RAMP_INCREMENT = DELAY_W'(10);
  localparam logic [RAMP_W-1:0]  RAMP_PERIOD    = RAMP_W'(100);
  localparam logic [DELAY_W-1:0] TARGET_RESET   = DELAY_W'(100);

  // stepping modes
  localparam logic [MODE_W-1:0] MODE_WAVE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_WAVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_FULL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HALF = 3'd6;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic               stepped;
    logic [DELAY_W-1:0] delay;
  } chan_out_t;

endpackage

/* src/dsp_if.sv */
// ----------------------------------------------------------------------------
// dsp_if: tick and result channels
// Valid/ready channels for the tick transactions and the result transactions.
// ----------------------------------------------------------------------------
interface dsp_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface dsp_out_if;
  logic                        valid;
  logic                        ready;
  logic [dsp_pkg::COIL_W-1:0]  coils_a;
  logic [dsp_pkg::COIL_W-1:0]  coils_b;
  logic                        stepped_a;
  logic                        stepped_b;
  logic [dsp_pkg::DELAY_W-1:0] delay_a;
  logic [dsp_pkg::DELAY_W-1:0] delay_b;

  modport source (output valid, output coils_a, output coils_b, output stepped_a,
                  output stepped_b, output delay_a, output delay_b, input ready);
  modport sink (input valid, input coils_a, input coils_b, input stepped_a,
                input stepped_b, input delay_a, input delay_b, output ready);
endinterface

/* src/dsp_channel.sv */
// ----------------------------------------------------------------------------
// dsp_channel: one motor channel
// Step countdown, coil pattern lookup, phase advance and delay ramp.
// ----------------------------------------------------------------------------
module dsp_channel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic                           ramp_go,
  input  logic [dsp_pkg::MODE_W-1:0]     mode,
  input  logic [dsp_pkg::PAT_W-1:0]      pat_wave,
  input  logic [dsp_pkg::PAT_W-1:0]      pat_full,
  input  logic [dsp_pkg::PAT_W-1:0]      pat_half,
  input  logic [dsp_pkg::DELAY_W-1:0]    target,
  output dsp_pkg::chan_out_t             res
);
  import dsp_pkg::*;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DELAY_W-1:0] cur_r, cur_nxt;
  logic [DELAY_W-1:0] count_r, count_nxt;
  logic [COIL_W-1:0]  coils_r, coils_nxt;

  logic [PAT_W-1:0]   tbl;
  logic [COIL_W-1:0]  nib;
  logic [1:0]         pos_inc;
  logic [POS_W:0]     pos_sum;
  logic               fire;
  logic [DELAY_W-1:0] tgt;
  logic [DELAY_W-1:0] diff;
  logic [DELAY_W-1:0] cur_ramp;

  always_comb begin
    unique case (mode)
      MODE_WAVE: begin
        tbl     = pat_wave;
        pos_inc = 2'd2;
      end
      MODE_FULL: begin
        tbl     = pat_full;
        pos_inc = 2'd2;
      end
      MODE_HALF: begin
        tbl     = pat_half;
        pos_inc = 2'd1;
      end
      default: begin
        // unused mode: blank coils, hold position
        tbl     = '0;
        pos_inc = 2'd0;
      end
    endcase
  end

  assign nib     = tbl[{pos_r, 2'b00} +: COIL_W];
  assign pos_sum = {1'b0, pos_r} + {{(POS_W-1){1'b0}}, pos_inc};
  assign fire    = step && (count_r <= DELAY_W'(1));

  // ramp toward target, zero target counts as one, clamp at target
  assign tgt = (target == '0) ? DELAY_W'(1) : target;

  always_comb begin
    if (cur_r < tgt) begin
      diff     = tgt - cur_r;
      cur_ramp = (diff <= RAMP_INCREMENT) ? tgt : cur_r + RAMP_INCREMENT;
    end else begin
      diff     = cur_r - tgt;
      cur_ramp = (diff <= RAMP_INCREMENT) ? tgt : cur_r - RAMP_INCREMENT;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    coils_nxt = coils_r;
    cur_nxt   = cur_r;
    if (step) begin
      if (fire) begin
        coils_nxt = nib;
        pos_nxt   = pos_sum[POS_W] ? '0 : pos_sum[POS_W-1:0];
        count_nxt = cur_r;
      end else begin
        count_nxt = count_r - DELAY_W'(1);
      end
      if (ramp_go) begin
        cur_nxt = cur_ramp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      cur_r   <= START_DELAY;
      count_r <= START_DELAY;
      coils_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      cur_r   <= cur_nxt;
      count_r <= count_nxt;
      coils_r <= coils_nxt;
    end
  end

  assign res.coils   = coils_nxt;
  assign res.stepped = fire;
  assign res.delay   = cur_nxt;

endmodule

/* src/dual_stepper_phase_sequencer_ramp.sv */
// ----------------------------------------------------------------------------
// dual_stepper_phase_sequencer_ramp: two-channel stepper sequencer with ramp
// Timer ticks step two motors through configured coil patterns while a
// shared ramp timer walks each step delay toward its target.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one tick transaction per timer event; tick = 0 passes no
//   time but still yields a result. out_ch returns exactly one result per
//   tick transaction: held coil drive, step flags and current delays.
//   The cfg_ port writes mode, target and pattern registers; write only
//   while no transaction is in flight.
// Pipeline: a transaction is captured in the input register and, once the
//   result register is free, processed into it; its result is offered from
//   the result register.
// Throughput: one transaction per cycle when not stalled; channel counters,
//   phase advance and ramp compare are each a single short add/compare.
// Stall: if out_ch.ready is low the result holds and the input register
//   fills; in_ch.ready then drops until the result is taken.
// Reset: rst_n (synchronous) clears both stages, loads START_DELAY into the
//   counters and delays, RAMP_PERIOD into the ramp timer, zero coils, and
//   the register reset values.
// ----------------------------------------------------------------------------
module dual_stepper_phase_sequencer_ramp (
  input  logic                              clk,
  input  logic                              rst_n,
  dsp_in_if.sink                            in_ch,
  dsp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [dsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dsp_pkg::*;

  // configuration registers
  logic [MODE_W-1:0]  mode_a_r, mode_b_r;
  logic [DELAY_W-1:0] target_a_r, target_b_r;
  logic [PAT_W-1:0]   pat_wave_r, pat_full_r, pat_half_r;

  // input stage
  logic               v1_r;
  logic               tick1_r;

  // result stage
  logic               out_valid_r;
  chan_out_t          res_a_r, res_b_r;

  // shared ramp timer
  logic [RAMP_W-1:0]  ramp_count_r, ramp_count_nxt;

  logic               advance;
  logic               step;
  logic               ramp_go;
  chan_out_t          res_a, res_b;

  // process the held transaction when the result register is free
  assign advance      = v1_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !v1_r || advance;
  assign step         = advance && tick1_r;
  assign ramp_go      = ramp_count_r <= RAMP_W'(1);

  always_comb begin
    ramp_count_nxt = ramp_count_r;
    if (step) begin
      ramp_count_nxt = ramp_go ? RAMP_PERIOD : ramp_count_r - RAMP_W'(1);
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_a_r   <= MODE_FULL;
      mode_b_r   <= MODE_FULL;
      target_a_r <= TARGET_RESET;
      target_b_r <= TARGET_RESET;
      pat_wave_r <= '0;
      pat_full_r <= '0;
      pat_half_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_A:   mode_a_r   <= cfg_data[MODE_W-1:0];
        CFG_MODE_B:   mode_b_r   <= cfg_data[MODE_W-1:0];
        CFG_TARGET_A: target_a_r <= cfg_data[DELAY_W-1:0];
        CFG_TARGET_B: target_b_r <= cfg_data[DELAY_W-1:0];
        CFG_PAT_WAVE: pat_wave_r <= cfg_data[PAT_W-1:0];
        CFG_PAT_FULL: pat_full_r <= cfg_data[PAT_W-1:0];
        CFG_PAT_HALF: pat_half_r <= cfg_data[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register and ramp timer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      ramp_count_r <= RAMP_PERIOD;
    end else begin
      ramp_count_r <= ramp_count_nxt;
      if (in_ch.valid && in_ch.ready) begin
        v1_r <= 1'b1;
      end else if (advance) begin
        v1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      tick1_r <= in_ch.tick;
    end
  end

  dsp_channel u_chan_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .ramp_go  (ramp_go),
    .mode     (mode_a_r),
    .pat_wave (pat_wave_r),
    .pat_full (pat_full_r),
    .pat_half (pat_half_r),
    .target   (target_a_r),
    .res      (res_a)
  );

  dsp_channel u_chan_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .ramp_go  (ramp_go),
    .mode     (mode_b_r),
    .pat_wave (pat_wave_r),
    .pat_full (pat_full_r),
    .pat_half (pat_half_r),
    .target   (target_b_r),
    .res      (res_b)
  );

  // result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_a_r <= res_a;
      res_b_r <= res_b;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.coils_a   = res_a_r.coils;
  assign out_ch.coils_b   = res_b_r.coils;
  assign out_ch.stepped_a = res_a_r.stepped;
  assign out_ch.stepped_b = res_b_r.stepped;
  assign out_ch.delay_a   = res_a_r.delay;
  assign out_ch.delay_b   = res_b_r.delay;

endmodule

/* src/dsp_checker.sv */
// ----------------------------------------------------------------------------
// dsp_checker: port-level checks for the dual stepper sequencer
// Watches the result channel and reset behavior of the top level.
// ----------------------------------------------------------------------------
module dsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [dsp_pkg::DELAY_W-1:0] delay_a,
  input logic [dsp_pkg::DELAY_W-1:0] delay_b,
  input logic                        stepped_a,
  input logic [dsp_pkg::COIL_W-1:0]  coils_a
);
  import dsp_pkg::*;

  // a reset cycle leaves no result pending
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(delay_a) && $stable(coils_a)
      && $stable(stepped_a))
    else $error("stalled result changed");

  // current delays never reach zero
  a_delay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (delay_a != '0) && (delay_b != '0))
    else $error("step delay is zero");

endmodule

bind dual_stepper_phase_sequencer_ramp dsp_checker u_dsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .delay_a   (out_ch.delay_a),
  .delay_b   (out_ch.delay_b),
  .stepped_a (out_ch.stepped_a),
  .coils_a   (out_ch.coils_a)
);

/* sim/tb_dual_stepper_phase_sequencer_ramp.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_stepper_phase_sequencer_ramp: self-checking bench for the sequencer
// Sends tick transactions under random handshake idling, mirrors both
// countdowns, phase positions and the shared ramp in a scoreboard, and
// compares every result transaction field by field with its prediction.
// ----------------------------------------------------------------------------
module tb_dual_stepper_phase_sequencer_ramp;
  import dsp_pkg::*;

  // mode code with no pattern table behind it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int LATENCY_CYCLES = 2;
  localparam int SETTLE_CYCLES  = LATENCY_CYCLES + 2;
  localparam int HOLD_CYCLES    = 60;
  localparam int CYCLE_LIMIT    = 1000000;
  localparam int PHASE1_ITEMS   = 500;
  localparam int STEP_GOAL      = 150;
  localparam int PHASE2_CAP     = 200;
  localparam int PHASE3A_ITEMS  = 300;
  localparam int PHASE3B_ITEMS  = 250;

  typedef struct packed {
    logic [COIL_W-1:0]  coils_a;
    logic [COIL_W-1:0]  coils_b;
    logic               stepped_a;
    logic               stepped_b;
    logic [DELAY_W-1:0] delay_a;
    logic [DELAY_W-1:0] delay_b;
  } tick_result_t;

  // Mirror of both motor channels and the ramp timer; holds the queue of
  // results that accepted ticks still owe.
  class stepper_scoreboard;
    logic [MODE_W-1:0]  mode      [2];
    logic [DELAY_W-1:0] target    [2];
    logic [PAT_W-1:0]   pat_wave;
    logic [PAT_W-1:0]   pat_full;
    logic [PAT_W-1:0]   pat_half;
    logic [POS_W-1:0]   position  [2];
    logic [DELAY_W-1:0] cur_delay [2];
    logic [DELAY_W-1:0] countdown [2];
    logic [COIL_W-1:0]  coils     [2];
    logic [RAMP_W-1:0]  ramp_left;
    tick_result_t       expected_q [$];
    int                 steps_total;
    int                 errors;

    function new();
      for (int c = 0; c < 2; c++) begin
        mode[c]      = MODE_FULL;
        target[c]    = TARGET_RESET;
        position[c]  = '0;
        cur_delay[c] = START_DELAY;
        countdown[c] = START_DELAY;
        coils[c]     = '0;
      end
      pat_wave    = '0;
      pat_full    = '0;
      pat_half    = '0;
      ramp_left   = RAMP_PERIOD;
      steps_total = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MODE_A:   mode[0]   = data[MODE_W-1:0];
        CFG_MODE_B:   mode[1]   = data[MODE_W-1:0];
        CFG_TARGET_A: target[0] = data[DELAY_W-1:0];
        CFG_TARGET_B: target[1] = data[DELAY_W-1:0];
        CFG_PAT_WAVE: pat_wave  = data[PAT_W-1:0];
        CFG_PAT_FULL: pat_full  = data[PAT_W-1:0];
        CFG_PAT_HALF: pat_half  = data[PAT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic tick);
      logic [PAT_W-1:0]   tbl;
      logic [3:0]         nxt;
      logic [DELAY_W-1:0] tgt;
      logic               hit [2];
      tick_result_t       res;
      hit[0] = 1'b0;
      hit[1] = 1'b0;
      if (tick) begin
        // steps first, each reloading from the delay before this tick's ramp
        for (int c = 0; c < 2; c++) begin
          if (countdown[c] > 1) begin
            countdown[c] = countdown[c] - DELAY_W'(1);
          end else begin
            case (mode[c])
              MODE_WAVE: tbl = pat_wave;
              MODE_FULL: tbl = pat_full;
              MODE_HALF: tbl = pat_half;
              default:   tbl = '0;
            endcase
            coils[c] = COIL_W'(tbl >> (4 * int'(position[c])));
            case (mode[c])
              MODE_WAVE, MODE_FULL: nxt = {1'b0, position[c]} + 4'd2;
              MODE_HALF:            nxt = {1'b0, position[c]} + 4'd1;
              default:              nxt = {1'b0, position[c]};
            endcase
            position[c]  = (nxt >= 4'd8) ? '0 : nxt[POS_W-1:0];
            countdown[c] = cur_delay[c];
            hit[c]       = 1'b1;
            steps_total++;
          end
        end
        if (ramp_left > 1) begin
          ramp_left = ramp_left - RAMP_W'(1);
        end else begin
          for (int c = 0; c < 2; c++) begin
            tgt = (target[c] == '0) ? DELAY_W'(1) : target[c];
            if (cur_delay[c] < tgt) begin
              cur_delay[c] = (tgt - cur_delay[c] <= RAMP_INCREMENT) ? tgt
                                                                   : cur_delay[c] + RAMP_INCREMENT;
            end else if (cur_delay[c] > tgt) begin
              cur_delay[c] = (cur_delay[c] - tgt <= RAMP_INCREMENT) ? tgt
                                                                   : cur_delay[c] - RAMP_INCREMENT;
            end
          end
          ramp_left = RAMP_PERIOD;
        end
      end
      res.coils_a   = coils[0];
      res.coils_b   = coils[1];
      res.stepped_a = hit[0];
      res.stepped_b = hit[1];
      res.delay_a   = cur_delay[0];
      res.delay_b   = cur_delay[1];
      expected_q.push_back(res);
    endfunction

    function void check_result(tick_result_t got);
      tick_result_t want;
      if (expected_q.size() == 0) begin
        $error("result transaction with no tick waiting: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.coils_a !== want.coils_a) begin
        $error("coils_a: expected %0h, got %0h", want.coils_a, got.coils_a);
        errors++;
      end
      if (got.coils_b !== want.coils_b) begin
        $error("coils_b: expected %0h, got %0h", want.coils_b, got.coils_b);
        errors++;
      end
      if (got.stepped_a !== want.stepped_a) begin
        $error("stepped_a: expected %0b, got %0b", want.stepped_a, got.stepped_a);
        errors++;
      end
      if (got.stepped_b !== want.stepped_b) begin
        $error("stepped_b: expected %0b, got %0b", want.stepped_b, got.stepped_b);
        errors++;
      end
      if (got.delay_a !== want.delay_a) begin
        $error("delay_a: expected %0d, got %0d", want.delay_a, got.delay_a);
        errors++;
      end
      if (got.delay_b !== want.delay_b) begin
        $error("delay_b: expected %0d, got %0d", want.delay_b, got.delay_b);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dsp_in_if  in_ch ();
  dsp_out_if out_ch ();

  stepper_scoreboard sb;
  tick_result_t      mon_result;

  // handshake idling, in percent of cycles; set by the stimulus per phase
  int tx_idle_pct;
  int rx_idle_pct;
  // receiver hold-off requests (stimulus side) and grants (receiver side)
  int hold_reqs;
  int hold_done;
  int items_sent;

  dual_stepper_phase_sequencer_ramp u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the handshakes never finish.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_dual_stepper_phase_sequencer_ramp: FAIL");
    $finish;
  end

  // Receiver: drop ready at random, or for a long stretch when a hold-off
  // is requested; count the stretch here so the sender keeps offering.
  initial begin
    int hold_left;
    hold_left    = 0;
    hold_done    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_done != hold_reqs) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Monitor: sample both channels at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_tick(in_ch.tick);
      end
      if (out_ch.valid && out_ch.ready) begin
        mon_result.coils_a   = out_ch.coils_a;
        mon_result.coils_b   = out_ch.coils_b;
        mon_result.stepped_a = out_ch.stepped_a;
        mon_result.stepped_b = out_ch.stepped_b;
        mon_result.delay_a   = out_ch.delay_a;
        mon_result.delay_b   = out_ch.delay_b;
        sb.check_result(mon_result);
      end
    end
  end

  // Offer one tick transaction after a random idle gap and hold it until
  // accepted. Valid stays high across back-to-back transactions.
  task automatic send_tick(input logic tick);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      in_ch.tick  <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.tick  <= tick;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Stop offering and wait until every tick has returned its result, then
  // let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all seven registers back to back; call only with the block idle.
  task automatic apply_setting(input logic [MODE_W-1:0] ma, input logic [MODE_W-1:0] mb,
                               input logic [DELAY_W-1:0] tgt_a,
                               input logic [DELAY_W-1:0] tgt_b,
                               input logic [PAT_W-1:0] pw, input logic [PAT_W-1:0] pf,
                               input logic [PAT_W-1:0] ph);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    idx = '{CFG_MODE_A, CFG_MODE_B, CFG_TARGET_A, CFG_TARGET_B,
            CFG_PAT_WAVE, CFG_PAT_FULL, CFG_PAT_HALF};
    val = '{CFG_DATA_W'(ma), CFG_DATA_W'(mb), CFG_DATA_W'(tgt_a), CFG_DATA_W'(tgt_b),
            pw, pf, ph};
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic early_ticks [5];
    logic late_ticks  [15];
    int   start_items;
    early_ticks = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    late_ticks  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                    1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    sb          = new();
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.tick  = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idle_pct = 38;
    rx_idle_pct = 84;
    hold_reqs   = 0;
    items_sent  = 0;

    // Hold reset once at the start, then release it.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle and real ticks under the reset register values.
    foreach (early_ticks[i]) send_tick(early_ticks[i]);
    drain();

    // Directed: extreme targets (zero, all ones), all-ones wave and all-zero full tables.
    apply_setting(MODE_WAVE, MODE_HALF, DELAY_W'(0), DELAY_W'(16'hFFFF),
                  32'hFFFF_FFFF, 32'h0000_0000, $urandom());
    foreach (late_ticks[i]) send_tick(late_ticks[i]);

    // Phase 1: sender idles lightly, receiver heavily.
    for (int i = 0; i < PHASE1_ITEMS; i++) begin
      // hold the receiver off long enough to back up the input
      if (i == 100) hold_reqs++;
      // pause the sender until the block has emptied
      if (i == 300) drain();
      send_tick($urandom_range(0, 3) != 0);
    end
    drain();

    // Phase 2: the other way round. Pull both targets to the floor so the
    // delays ramp down; motor B runs in the unused mode.
    tx_idle_pct = 84;
    rx_idle_pct = 38;
    apply_setting(MODE_FULL, MODE_UNUSED, DELAY_W'(1), DELAY_W'(1),
                  $urandom(), $urandom(), $urandom());
    start_items = items_sent;
    while (sb.steps_total < STEP_GOAL && items_sent - start_items < PHASE2_CAP) begin
      send_tick($urandom_range(0, 7) != 0);
    end
    drain();

    // Phase 3: no idling on either side; half and wave modes at full rate.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    apply_setting(MODE_HALF, MODE_WAVE, DELAY_W'(1), DELAY_W'($urandom_range(2, 4)),
                  $urandom(), $urandom(), $urandom());
    for (int i = 0; i < PHASE3A_ITEMS; i++) send_tick($urandom_range(0, 7) != 0);
    drain();

    // Switch motor A to wave from wherever half stepping left it; an odd
    // position stays odd until it steps past seven and wraps to zero.
    apply_setting(MODE_WAVE, MODE_FULL, DELAY_W'(1), DELAY_W'(1),
                  $urandom(), $urandom(), $urandom());
    for (int i = 0; i < PHASE3B_ITEMS; i++) send_tick($urandom_range(0, 7) != 0);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_dual_stepper_phase_sequencer_ramp: PASS");
    end else begin
      $display("tb_dual_stepper_phase_sequencer_ramp: FAIL");
    end
    $finish;
  end

endmodule
